/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL. Defining NO_ASSERTIONS removes every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hw/rtl/sv39ptw_pkg.sv */
package sv39ptw_pkg;

    // Field widths of the stream transactions.
    localparam int VA_W      = 39;
    localparam int ACCESS_W  = 2;
    localparam int PTE_W     = 64;
    localparam int ADDR_W    = 56;
    localparam int ROOT_W    = 44;
    localparam int RKIND_W   = 2;
    localparam int LEVEL_W   = 2;
    localparam int IN_DATA_W = 112;
    localparam int OUT_DATA_W = 176;

    // Input transaction kinds.
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_PTE     = 1'b1;

    // Access kinds.
    localparam logic [ACCESS_W-1:0] ACCESS_FETCH = 2'd0;

    // Result kinds.
    localparam logic [RKIND_W-1:0] RK_READ      = 2'd0;
    localparam logic [RKIND_W-1:0] RK_WRITEBACK = 2'd1;
    localparam logic [RKIND_W-1:0] RK_DONE      = 2'd2;
    localparam logic [RKIND_W-1:0] RK_FAULT     = 2'd3;

    // Page-table entry flag bits.
    localparam logic [PTE_W-1:0] PTE_V = 64'h01;
    localparam logic [PTE_W-1:0] PTE_A = 64'h40;
    localparam logic [PTE_W-1:0] PTE_D = 64'h80;

    // One result transaction.
    typedef struct packed {
        logic [RKIND_W-1:0] kind;
        logic [ADDR_W-1:0]  addr;
        logic [PTE_W-1:0]   wdata;
        logic [ADDR_W-1:0]  phys;
        logic               last;
    } result_t;

    // Byte offset of the entry selected by the VPN field of one level.
    function automatic logic [ADDR_W-1:0] vpn_offset(input logic [VA_W-1:0] va,
                                                      input logic [LEVEL_W-1:0] lvl);
        logic [8:0] vpn;
        begin
            unique case (lvl)
                2'd0:    vpn = va[20:12];
                2'd1:    vpn = va[29:21];
                2'd2:    vpn = va[38:30];
                default: vpn = 9'd0;
            endcase
            vpn_offset = {44'd0, vpn, 3'b000};
        end
    endfunction

endpackage

/* hw/rtl/sv39_page_table_walker.sv */
// Sv39 page-table walker, driven by stream transactions.
// Slave stream: tuser is 0 for a translation request (virtual address and access
// kind in tdata) and 1 for page-table entry data returned from memory.
// Master stream: tuser gives the result kind (entry read, entry write-back,
// translation done, invalid entry fault); tlast marks the last result of an input.
// Configuration: cfg_wr_en writes the root page number taken from satp.
// An input transaction is held in the input register, evaluated from there, and
// its first result is registered in the single result register for the master side.
// Throughput: one input per cycle for requests and non-leaf entries while the
// receiver takes results; a leaf entry yields a write-back followed by a done
// result, and no input is evaluated until the done result enters the result register.
// Requests during a walk and entry data while idle are dropped without a result.
// Reset clears the walk state, the root page number and both stream stages.
// When the receiver stalls, the result register holds and the input register
// fills; s_axis_tready then drops until the result is taken.
module sv39_page_table_walker #(
    parameter int LEVELS         = 3,
    parameter int PHYS_ADDR_BITS = 56
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port.
    input  logic                              cfg_wr_en,
    input  logic [sv39ptw_pkg::ROOT_W-1:0]    cfg_wr_data,
    // Slave stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: virt_addr[38:0], access_kind[40:39], pte_data[104:41], zeros[111:105]
    input  logic [sv39ptw_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // tuser: kind[0]
    input  logic                              s_axis_tuser,
    // Master stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: mem_addr[55:0], mem_wdata[119:56], phys_addr[175:120]
    output logic [sv39ptw_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: result_kind[1:0]
    output logic [sv39ptw_pkg::RKIND_W-1:0]    m_axis_tuser,
    output logic                               m_axis_tlast
);
    import sv39ptw_pkg::*;

    `include "assert_macros.svh"

    localparam logic [ADDR_W-1:0]  PA_MASK   = (ADDR_W'(1) << PHYS_ADDR_BITS) - ADDR_W'(1);
    localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(LEVELS - 1);

    // Configuration register.
    logic [ROOT_W-1:0] root_ppn_reg;

    // Input register.
    logic                in_valid_reg;
    logic                in_kind_reg;
    logic [VA_W-1:0]     in_vaddr_reg;
    logic [ACCESS_W-1:0] in_access_reg;
    logic [PTE_W-1:0]    in_pte_reg;

    // Walk state.
    logic                busy_reg, busy_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic [VA_W-1:0]     vaddr_reg, vaddr_next;
    logic [ACCESS_W-1:0] access_reg, access_next;
    logic [ADDR_W-1:0]   entry_addr_reg, entry_addr_next;

    // Result register and the pending done result of a leaf.
    logic              out_valid_reg;
    result_t           out_reg;
    logic              pend_valid_reg;
    logic [ADDR_W-1:0] pend_phys_reg;

    // Evaluation results.
    logic [1:0]        res_count;
    result_t           res_first;
    logic [ADDR_W-1:0] res_phys;
    logic [ADDR_W-1:0] pte_base;
    logic [PTE_W-1:0]  mark;

    logic out_free;
    logic fire;
    logic s_accept;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign fire     = in_valid_reg && out_free && !pend_valid_reg;
    assign s_accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = !in_valid_reg || fire;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.phys, out_reg.wdata, out_reg.addr};
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;

    // Evaluate the registered input against the walk state.
    always_comb
    begin
        busy_next       = busy_reg;
        level_next      = level_reg;
        vaddr_next      = vaddr_reg;
        access_next     = access_reg;
        entry_addr_next = entry_addr_reg;
        res_count       = 2'd0;
        res_first       = '0;
        pte_base        = {in_pte_reg[53:10], 12'd0} & PA_MASK;
        mark            = (access_reg == ACCESS_FETCH) ? PTE_A : PTE_D;
        res_phys        = (pte_base + {44'd0, vaddr_reg[11:0]}) & PA_MASK;
        if (in_kind_reg == KIND_REQUEST)
        begin
            if (!busy_reg)
            begin
                busy_next       = 1'b1;
                vaddr_next      = in_vaddr_reg;
                access_next     = in_access_reg;
                level_next      = TOP_LEVEL;
                entry_addr_next = ({root_ppn_reg, 12'd0}
                                   + vpn_offset(in_vaddr_reg, TOP_LEVEL)) & PA_MASK;
                res_count       = 2'd1;
                res_first       = '{RK_READ, entry_addr_next, '0, '0, 1'b1};
            end
        end
        else if (busy_reg)
        begin
            if ((in_pte_reg & PTE_V) == '0)
            begin
                // Invalid entry ends the walk.
                busy_next = 1'b0;
                res_count = 2'd1;
                res_first = '{RK_FAULT, entry_addr_reg, '0, '0, 1'b1};
            end
            else if (level_reg != '0)
            begin
                // Step down one level.
                level_next      = level_reg - LEVEL_W'(1);
                entry_addr_next = (pte_base + vpn_offset(vaddr_reg, level_next)) & PA_MASK;
                res_count       = 2'd1;
                res_first       = '{RK_READ, entry_addr_next, '0, '0, 1'b1};
            end
            else
            begin
                // Leaf: write back the entry, then report the address.
                busy_next = 1'b0;
                res_count = 2'd2;
                res_first = '{RK_WRITEBACK, entry_addr_reg, in_pte_reg | mark, '0, 1'b0};
            end
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_ppn_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            root_ppn_reg <= cfg_wr_data;
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_kind_reg   <= s_axis_tuser;
            in_vaddr_reg  <= s_axis_tdata[38:0];
            in_access_reg <= s_axis_tdata[40:39];
            in_pte_reg    <= s_axis_tdata[104:41];
        end
    end

    // Walk state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            level_reg      <= '0;
            vaddr_reg      <= '0;
            access_reg     <= '0;
            entry_addr_reg <= '0;
        end
        else if (fire)
        begin
            busy_reg       <= busy_next;
            level_reg      <= level_next;
            vaddr_reg      <= vaddr_next;
            access_reg     <= access_next;
            entry_addr_reg <= entry_addr_next;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (pend_valid_reg && out_free)
        begin
            out_valid_reg  <= 1'b1;
            pend_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg  <= (res_count != 2'd0);
            pend_valid_reg <= (res_count == 2'd2);
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (pend_valid_reg && out_free)
        begin
            out_reg <= '{RK_DONE, '0, '0, pend_phys_reg, 1'b1};
        end
        else if (fire)
        begin
            out_reg       <= res_first;
            pend_phys_reg <= res_phys;
        end
    end

    // A pending done result always sits behind a write-back in the result register.
    `ASSERT_SAME(a_pend_behind_wb, clk, rst_n, pend_valid_reg,
                 out_valid_reg && out_reg.kind == RK_WRITEBACK,
                 "pending done without a write-back ahead of it")

    // A result that is not the last of its input has its done result pending.
    `ASSERT_SAME(a_notlast_pend, clk, rst_n, m_axis_tvalid && !m_axis_tlast,
                 pend_valid_reg, "non-last result without a pending follower")

    // A read request is shown only during a walk.
    `ASSERT_SAME(a_read_busy, clk, rst_n, m_axis_tvalid && m_axis_tuser == RK_READ,
                 busy_reg, "entry read request while no walk is active")

    // Done and fault results end the walk.
    `ASSERT_SAME(a_end_idle, clk, rst_n,
                 m_axis_tvalid && (m_axis_tuser == RK_DONE || m_axis_tuser == RK_FAULT),
                 !busy_reg, "walk still active after done or fault")

endmodule

/* test/tb_sv39_page_table_walker.sv */
module tb_sv39_page_table_walker;

    timeunit 1ns;
    timeprecision 1ps;

    import sv39ptw_pkg::*;

    localparam int LEVELS         = 3;
    localparam int PHYS_ADDR_BITS = 56;

    // Access kinds beyond the fetch code that the package provides.
    localparam logic [ACCESS_W-1:0] ACCESS_LOAD     = 2'd1;
    localparam logic [ACCESS_W-1:0] ACCESS_STORE    = 2'd2;
    localparam logic [ACCESS_W-1:0] ACCESS_RESERVED = 2'd3;

    localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(LEVELS - 1);
    localparam logic [ROOT_W-1:0]  ROOT_MAX  = '1;

    // A valid leaf entry whose page number is all ones and whose A and D bits are clear.
    localparam logic [PTE_W-1:0] PTE_PPN_MAX = 64'h003F_FFFF_FFFF_FC01;

    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE_DELAY = 8;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [ROOT_W-1:0]     cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [RKIND_W-1:0]    m_axis_tuser;
    logic                  m_axis_tlast;

    // Traffic shaping, changed between phases.
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    bit hold_request = 1'b0;
    int hold_left = 0;

    // Accepted input transactions that caused at least one result.
    int items_taken = 0;

    sv39_page_table_walker #(
        .LEVELS         (LEVELS),
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Shadow walker state and the queue of results it has predicted.
    class walk_scoreboard;
        logic [ROOT_W-1:0]   root_ppn;
        bit                  busy;
        logic [LEVEL_W-1:0]  level;
        logic [VA_W-1:0]     held_va;
        logic [ACCESS_W-1:0] held_access;
        logic [ADDR_W-1:0]   entry_addr;
        result_t             expected_results[$];
        int                  failures;

        function new();
            root_ppn = '0;
            busy = 1'b0;
            level = '0;
            held_va = '0;
            held_access = '0;
            entry_addr = '0;
            failures = 0;
        endfunction

        function void set_root(logic [ROOT_W-1:0] value);
            root_ppn = value;
        endfunction

        // Byte offset of the entry that the VPN field of one level selects.
        function logic [ADDR_W-1:0] vpn_offset_of(logic [VA_W-1:0] va, logic [LEVEL_W-1:0] lvl);
            logic [ADDR_W-1:0] off;
            off = '0;
            off[11:3] = va[12 + 9 * lvl +: 9];
            return off;
        endfunction

        function void push(logic [RKIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                           logic [PTE_W-1:0] wdata, logic [ADDR_W-1:0] phys, logic last);
            result_t r;
            r.kind = kind;
            r.addr = addr;
            r.wdata = wdata;
            r.phys = phys;
            r.last = last;
            expected_results.push_back(r);
        endfunction

        // Advances the walk by one accepted transaction; returns how many results it causes.
        function int predict_walk_step(logic kind, logic [VA_W-1:0] va,
                                       logic [ACCESS_W-1:0] acc, logic [PTE_W-1:0] pte);
            logic [ADDR_W-1:0] page;
            logic [PTE_W-1:0]  mark;
            page = {pte[ADDR_W-3:10], 12'h000};
            if (kind == KIND_REQUEST) begin
                if (busy)
                    return 0;
                busy = 1'b1;
                held_va = va;
                held_access = acc;
                level = TOP_LEVEL;
                entry_addr = {root_ppn, 12'h000} + vpn_offset_of(va, level);
                push(RK_READ, entry_addr, '0, '0, 1'b1);
                return 1;
            end
            if (!busy)
                return 0;
            // An invalid entry ends the walk at any level, the leaf included.
            if ((pte & PTE_V) == '0) begin
                busy = 1'b0;
                push(RK_FAULT, entry_addr, '0, '0, 1'b1);
                return 1;
            end
            if (level != '0) begin
                level = level - 1'b1;
                entry_addr = page + vpn_offset_of(held_va, level);
                push(RK_READ, entry_addr, '0, '0, 1'b1);
                return 1;
            end
            // Leaf: write back with A for a fetch and D for anything else, then finish.
            mark = (held_access == ACCESS_FETCH) ? PTE_A : PTE_D;
            push(RK_WRITEBACK, entry_addr, pte | mark, '0, 1'b0);
            push(RK_DONE, '0, '0, page | ADDR_W'(held_va[11:0]), 1'b1);
            busy = 1'b0;
            return 2;
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s expected 0x%0h actual 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic [RKIND_W-1:0] kind, logic [OUT_DATA_W-1:0] data,
                                   logic last);
            result_t want;
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction: result_kind %0d mem_addr 0x%0h",
                       kind, data[55:0]);
                failures++;
                return;
            end
            want = expected_results.pop_front();
            compare("result_kind", 64'(want.kind), 64'(kind));
            compare("mem_addr", 64'(want.addr), 64'(data[55:0]));
            compare("mem_wdata", want.wdata, data[119:56]);
            compare("phys_addr", 64'(want.phys), 64'(data[175:120]));
            compare("last", 64'(want.last), 64'(last));
        endfunction
    endclass

    walk_scoreboard sb = new();

    // Clock generation.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Result monitor: outputs are stable at the falling edge before the accepting edge.
    always @(negedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end

    // Watchdog.
    initial
    begin
        #2_000_000;
        $display("tb_sv39_page_table_walker failed");
        $finish;
    end

    function automatic logic [VA_W-1:0] random_va();
        return VA_W'({$urandom, $urandom});
    endfunction

    function automatic logic [ACCESS_W-1:0] random_access();
        return ACCESS_W'($urandom_range(3));
    endfunction

    // Random entry content, sometimes with the page number at an extreme.
    function automatic logic [PTE_W-1:0] random_entry(bit invalid);
        logic [PTE_W-1:0] pte;
        int pick;
        pte = {$urandom, $urandom};
        pick = $urandom_range(7);
        if (pick == 0)
            pte[ADDR_W-3:10] = '1;
        else if (pick == 1)
            pte[ADDR_W-3:10] = '0;
        pte[0] = !invalid;
        return pte;
    endfunction

    // Offers one input transaction and waits until it is accepted.
    task automatic send_item(logic kind, logic [VA_W-1:0] va, logic [ACCESS_W-1:0] acc,
                             logic [PTE_W-1:0] pte);
        bit accepted;
        accepted = 1'b0;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {pte, acc, va};
        while (!accepted)
        begin
            @(negedge clk);
            accepted = s_axis_tready;
            @(posedge clk);
        end
        if (sb.predict_walk_step(kind, va, acc, pte) > 0)
            items_taken++;
        // The sender goes idle for each following cycle with the phase's probability.
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Ends any open walk and waits until the block has gone quiet.
    task automatic settle();
        if (sb.busy)
            send_item(KIND_PTE, '0, ACCESS_FETCH, '0);
        s_axis_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_DELAY) @(posedge clk);
    endtask

    task automatic write_root(logic [ROOT_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_root(value);
    endtask

    // Mostly complete walks with random content, plus stray and truncated sequences.
    task automatic run_random_walks(int target);
        int start_count;
        int entries;
        logic [PTE_W-1:0] pte;
        start_count = items_taken;
        while (items_taken - start_count < target)
        begin
            if ($urandom_range(99) < 10)
            begin
                send_item(1'($urandom_range(1)), random_va(), random_access(),
                          random_entry(1'b0));
            end
            else
            begin
                send_item(KIND_REQUEST, random_va(), random_access(), random_entry(1'b0));
                entries = ($urandom_range(99) < 10) ? $urandom_range(0, 2) : LEVELS;
                for (int i = 0; i < entries; i++)
                begin
                    pte = random_entry($urandom_range(99) < 8);
                    send_item(KIND_PTE, random_va(), random_access(), pte);
                    if (!pte[0])
                        break;
                end
            end
        end
    endtask

    task automatic run_phase(logic [ROOT_W-1:0] root, int idle_pct, int stall_pct,
                             bit pressure, int target);
        settle();
        write_root(root);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        if (pressure)
            hold_request = 1'b1;
        run_random_walks(target);
    endtask

    // Main sequence.
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed walks with the root page number still at its reset value.
        send_item(KIND_PTE, '1, ACCESS_RESERVED, '1);
        send_item(KIND_REQUEST, '0, ACCESS_FETCH, '0);
        send_item(KIND_REQUEST, '1, ACCESS_STORE, '1);
        send_item(KIND_PTE, '0, ACCESS_FETCH, PTE_V);
        send_item(KIND_PTE, '0, ACCESS_FETCH, '1);
        send_item(KIND_PTE, '0, ACCESS_FETCH, PTE_PPN_MAX);

        // Invalid entry at the root level.
        send_item(KIND_REQUEST, '1, ACCESS_LOAD, '0);
        send_item(KIND_PTE, '0, ACCESS_FETCH, ~PTE_V);

        // Invalid entry at the leaf.
        send_item(KIND_REQUEST, 39'h55_5555_5555, ACCESS_STORE, '0);
        send_item(KIND_PTE, '0, ACCESS_FETCH, '1);
        send_item(KIND_PTE, '0, ACCESS_FETCH, PTE_V);
        send_item(KIND_PTE, '0, ACCESS_FETCH, ~PTE_V);

        // Reserved access kind marks the entry dirty.
        send_item(KIND_REQUEST, random_va(), ACCESS_RESERVED, '0);
        send_item(KIND_PTE, '0, ACCESS_FETCH, '1);
        send_item(KIND_PTE, '0, ACCESS_FETCH, '1);
        send_item(KIND_PTE, '0, ACCESS_FETCH, (random_entry(1'b0) & ~PTE_D) | PTE_V);

        // Invalid entry at the middle level.
        send_item(KIND_REQUEST, '1, ACCESS_FETCH, '0);
        send_item(KIND_PTE, '0, ACCESS_FETCH, PTE_V);
        send_item(KIND_PTE, '1, ACCESS_FETCH, ~PTE_V);

        // Store to page zero with the largest offset.
        send_item(KIND_REQUEST, '1, ACCESS_STORE, '0);
        send_item(KIND_PTE, '0, ACCESS_FETCH, PTE_V);
        send_item(KIND_PTE, '0, ACCESS_FETCH, PTE_V);
        send_item(KIND_PTE, '0, ACCESS_FETCH, PTE_V);

        // Random phases under different root settings and traffic patterns.
        run_phase(ROOT_MAX, 0, 0, 1'b1, 100);
        run_phase(ROOT_W'({$urandom, $urandom}), 79, 0, 1'b0, 100);
        run_phase('0, 0, 79, 1'b0, 100);
        run_phase(ROOT_W'({$urandom, $urandom}), 20, 20, 1'b0, 100);
        run_phase(ROOT_W'({$urandom, $urandom}), 0, 0, 1'b0, 100);

        settle();
        if (sb.failures == 0)
            $display("tb_sv39_page_table_walker passed");
        else
            $display("tb_sv39_page_table_walker failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/sv39ptw_pkg.sv
hw/rtl/sv39_page_table_walker.sv
test/tb_sv39_page_table_walker.sv
